[design/rsc_pkg.sv]
// ----------------------------------------------------------------------------
// rsc_pkg
// Shared types and constants for the radix string conversion unit.
// ----------------------------------------------------------------------------
package rsc_pkg;

    localparam int MAX_SYMBOLS = 64;
    localparam int MAX_DIGITS  = 32;

    localparam int VALUE_W    = 32;
    localparam int CHAR_W     = 8;
    localparam int CMD_W      = 2;
    localparam int SEEN_DEPTH = 1 << CHAR_W;

    localparam int SYM_IDX_W = $clog2(MAX_SYMBOLS);
    localparam int LEN_W     = $clog2(MAX_SYMBOLS + 1);
    localparam int DIG_IDX_W = $clog2(MAX_DIGITS);
    localparam int DIG_CNT_W = $clog2(MAX_DIGITS + 1);
    localparam int BIT_CNT_W = $clog2(VALUE_W);
    localparam int TRIAL_W   = SYM_IDX_W + 1;

    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 8;

    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;

    typedef enum logic [CMD_W-1:0] {
        CMD_APPEND  = 2'd0,
        CMD_CONVERT = 2'd1,
        CMD_CLEAR   = 2'd2,
        CMD_NONE    = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ERR,
        ST_SIGN,
        ST_DIV,
        ST_RD_DIG,
        ST_RD_SYM,
        ST_OUT
    } state_t;

endpackage

[design/radix_string_conversion_unit.sv]
// ----------------------------------------------------------------------------
// radix_string_conversion_unit
// Keeps a digit alphabet and emits signed integers as digit strings, most
// significant digit first, in base equal to the alphabet length.
// ----------------------------------------------------------------------------
// A convert runs the bit-serial restoring divider (one quotient bit per cycle,
// the push on the last) once per digit, then reads the digit stack and the
// alphabet for each emitted digit; a minus sign goes out first for a negative
// value. One item is in work at a time.
// Reset (aresetn low, synchronous) empties the alphabet and the seen map.
module radix_string_conversion_unit (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [rsc_pkg::S_TDATA_W-1:0]    s_tdata,   // symbol[7:0], value[39:8]
    input  logic [rsc_pkg::CMD_W-1:0]        s_tuser,   // cmd[1:0]
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [rsc_pkg::M_TDATA_W-1:0]    m_tdata,   // out_char[7:0]
    output logic                             m_tuser,   // status[0]
    output logic                             m_tlast
);
    import rsc_pkg::*;

    state_t                 state_reg, state_next;
    logic [LEN_W-1:0]       len_reg, len_next;
    logic                   bad_reg, bad_next;
    logic [SEEN_DEPTH-1:0]  seen_reg, seen_next;
    logic [VALUE_W-1:0]     quo_reg, quo_next;
    logic [SYM_IDX_W-1:0]   rem_reg, rem_next;
    logic [BIT_CNT_W-1:0]   bit_cnt_reg, bit_cnt_next;
    logic [DIG_CNT_W-1:0]   dig_cnt_reg, dig_cnt_next;
    logic [SYM_IDX_W-1:0]   dig_rd_reg;
    logic [CHAR_W-1:0]      sym_rd_reg;

    logic [CHAR_W-1:0]      alpha_mem [MAX_SYMBOLS];
    logic [SYM_IDX_W-1:0]   dig_mem   [MAX_DIGITS];

    cmd_t                   s_cmd;
    logic [CHAR_W-1:0]      s_symbol;
    logic [VALUE_W-1:0]     s_value;
    logic                   in_beat, out_beat;
    logic                   append_wr, digit_wr;
    logic [TRIAL_W-1:0]     trial, trial_base;
    logic                   fits;
    logic [SYM_IDX_W-1:0]   step_rem;
    logic [VALUE_W-1:0]     step_quo;
    logic                   last_bit;
    logic [DIG_CNT_W-1:0]   dig_top;

    assign s_cmd    = cmd_t'(s_tuser);
    assign s_symbol = s_tdata[CHAR_W-1:0];
    assign s_value  = s_tdata[CHAR_W+VALUE_W-1:CHAR_W];
    assign in_beat  = s_tvalid && s_tready;
    assign out_beat = m_tvalid && m_tready;

    // one restoring division step
    assign trial      = {rem_reg, quo_reg[VALUE_W-1]};
    assign trial_base = TRIAL_W'(len_reg);
    assign fits       = (trial >= trial_base);
    assign step_rem   = fits ? SYM_IDX_W'(trial - trial_base) : SYM_IDX_W'(trial);
    assign step_quo   = {quo_reg[VALUE_W-2:0], fits};
    assign last_bit   = (bit_cnt_reg == BIT_CNT_W'(VALUE_W - 1));
    assign dig_top    = dig_cnt_reg - DIG_CNT_W'(1);

    assign append_wr = in_beat && (s_cmd == CMD_APPEND)
                       && (len_reg < LEN_W'(MAX_SYMBOLS));
    assign digit_wr  = (state_reg == ST_DIV) && last_bit
                       && (dig_cnt_reg < DIG_CNT_W'(MAX_DIGITS));

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_beat && (s_cmd == CMD_CONVERT)) begin
                    if (bad_reg || (len_reg < LEN_W'(2))) begin
                        state_next = ST_ERR;
                    end else if (s_value[VALUE_W-1]) begin
                        state_next = ST_SIGN;
                    end else begin
                        state_next = ST_DIV;
                    end
                end
            end
            ST_ERR: begin
                if (out_beat) state_next = ST_IDLE;
            end
            ST_SIGN: begin
                if (out_beat) state_next = ST_DIV;
            end
            ST_DIV: begin
                if (last_bit && (step_quo == '0)) state_next = ST_RD_DIG;
            end
            ST_RD_DIG: state_next = ST_RD_SYM;
            ST_RD_SYM: state_next = ST_OUT;
            ST_OUT: begin
                if (out_beat) begin
                    state_next = (dig_cnt_reg == DIG_CNT_W'(1)) ? ST_IDLE : ST_RD_DIG;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // datapath next values
    always_comb begin
        len_next     = len_reg;
        bad_next     = bad_reg;
        seen_next    = seen_reg;
        quo_next     = quo_reg;
        rem_next     = rem_reg;
        bit_cnt_next = bit_cnt_reg;
        dig_cnt_next = dig_cnt_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_beat) begin
                    unique case (s_cmd)
                        CMD_APPEND: begin
                            if (len_reg >= LEN_W'(MAX_SYMBOLS)) begin
                                bad_next = 1'b1;
                            end else begin
                                if ((s_symbol == CHAR_PLUS) || (s_symbol == CHAR_MINUS)
                                    || seen_reg[s_symbol]) begin
                                    bad_next = 1'b1;
                                end
                                seen_next[s_symbol] = 1'b1;
                                len_next = len_reg + LEN_W'(1);
                            end
                        end
                        CMD_CLEAR: begin
                            seen_next = '0;
                            len_next  = '0;
                            bad_next  = 1'b0;
                        end
                        CMD_CONVERT: begin
                            quo_next     = s_value[VALUE_W-1] ? (~s_value + VALUE_W'(1))
                                                              : s_value;
                            rem_next     = '0;
                            bit_cnt_next = '0;
                            dig_cnt_next = '0;
                        end
                        CMD_NONE: ;
                        default: ;
                    endcase
                end
            end
            ST_DIV: begin
                quo_next     = step_quo;
                bit_cnt_next = bit_cnt_reg + BIT_CNT_W'(1);
                if (last_bit) begin
                    rem_next = '0;
                    if (digit_wr) dig_cnt_next = dig_cnt_reg + DIG_CNT_W'(1);
                end else begin
                    rem_next = step_rem;
                end
            end
            ST_OUT: begin
                if (out_beat) dig_cnt_next = dig_top;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            len_reg   <= '0;
            bad_reg   <= 1'b0;
            seen_reg  <= '0;
        end else begin
            state_reg <= state_next;
            len_reg   <= len_next;
            bad_reg   <= bad_next;
            seen_reg  <= seen_next;
        end
    end

    always_ff @(posedge aclk) begin
        quo_reg     <= quo_next;
        rem_reg     <= rem_next;
        bit_cnt_reg <= bit_cnt_next;
        dig_cnt_reg <= dig_cnt_next;
    end

    // alphabet store
    always_ff @(posedge aclk) begin
        if (append_wr) alpha_mem[len_reg[SYM_IDX_W-1:0]] <= s_symbol;
        if (state_reg == ST_RD_SYM) sym_rd_reg <= alpha_mem[dig_rd_reg];
    end

    // digit stack, pushed LSD first and popped MSD first
    always_ff @(posedge aclk) begin
        if (digit_wr) dig_mem[dig_cnt_reg[DIG_IDX_W-1:0]] <= step_rem;
        if (state_reg == ST_RD_DIG) dig_rd_reg <= dig_mem[dig_top[DIG_IDX_W-1:0]];
    end

    // outputs
    always_comb begin
        s_tready = (state_reg == ST_IDLE);
        m_tvalid = 1'b0;
        m_tdata  = '0;
        m_tuser  = 1'b0;
        m_tlast  = 1'b0;
        unique case (state_reg)
            ST_ERR: begin
                m_tvalid = 1'b1;
                m_tuser  = 1'b1;
                m_tlast  = 1'b1;
            end
            ST_SIGN: begin
                m_tvalid = 1'b1;
                m_tdata  = M_TDATA_W'(CHAR_MINUS);
            end
            ST_OUT: begin
                m_tvalid = 1'b1;
                m_tdata  = M_TDATA_W'(sym_rd_reg);
                m_tlast  = (dig_cnt_reg == DIG_CNT_W'(1));
            end
            default: ;
        endcase
    end

endmodule
